// ===== rtl/core/drp_pkg.sv =====
package drp_pkg;

    localparam int ADC_BITS = 12;
    localparam int RES_W    = 17;
    // resistance is only resolved below the top breakpoint, so 14 bits suffice
    localparam int QUO_W    = 14;
    localparam int NUM_W    = ADC_BITS + RES_W;
    localparam int DIV_W    = ADC_BITS + QUO_W;
    localparam int GRAM_W   = 13;
    localparam int CHAN_W   = 2;
    localparam int REGION_W = 2;
    localparam int SEG_W    = 3;
    localparam int DELTA_W  = 11;
    localparam int MUL_W    = 4;
    localparam int PROD_W   = 15;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W  = 20;
    localparam int SCALED_W = PROD_W + RECIP_W;

    // front stage, compare stage, one stage per quotient bit, four curve stages
    localparam int PIPE_LATENCY = QUO_W + 6;

    localparam logic [ADC_BITS-1:0] FULL_SCALE = '1;
    localparam logic [RES_W-1:0]    RES_RESET  = 17'd10000;

    localparam int CURVE_POINTS = 7;
    localparam logic [QUO_W-1:0] CURVE_OHM [CURVE_POINTS] = '{
        14'd8500, 14'd6500, 14'd5000, 14'd3300, 14'd2700, 14'd2300, 14'd2000
    };
    localparam logic [GRAM_W-1:0] CURVE_GRAM [CURVE_POINTS] = '{
        13'd0, 13'd500, 13'd1000, 13'd2000, 13'd3000, 13'd4000, 13'd5000
    };

    // ceil(2^RECIP_SHIFT / b): exact floor for products below 2^15
    localparam int RECIP_BY2  = ((1 << RECIP_SHIFT) + 1) / 2;
    localparam int RECIP_BY3  = ((1 << RECIP_SHIFT) + 2) / 3;
    localparam int RECIP_BY4  = ((1 << RECIP_SHIFT) + 3) / 4;
    localparam int RECIP_BY17 = ((1 << RECIP_SHIFT) + 16) / 17;

    typedef enum logic [REGION_W-1:0] {
        REGION_NONE   = 2'd0,
        REGION_INTERP = 2'd1,
        REGION_FULL   = 2'd2
    } drp_region_t;

    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic              no_load;
    } drp_tag_t;

    // slope of each segment as gram/ohm = mul / div
    function automatic logic [MUL_W-1:0] seg_mul(input logic [SEG_W-1:0] seg);
        logic [MUL_W-1:0] m;
        case (seg)
            3'd0, 3'd1: m = 4'd1;
            3'd2, 3'd5: m = 4'd10;
            3'd3, 3'd4: m = 4'd5;
            default:    m = 4'd0;
        endcase
        return m;
    endfunction

    function automatic logic [RECIP_W-1:0] seg_recip(input logic [SEG_W-1:0] seg);
        logic [RECIP_W-1:0] r;
        case (seg)
            3'd0:             r = RECIP_W'(RECIP_BY4);
            3'd1, 3'd3, 3'd5: r = RECIP_W'(RECIP_BY3);
            3'd2:             r = RECIP_W'(RECIP_BY17);
            3'd4:             r = RECIP_W'(RECIP_BY2);
            default:          r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/divider_resistance_to_pressure.sv =====
// converts a divider-node adc count into a load in grams via the sensor resistance
//
// input: raise start for one cycle with adc_count and channel; a beat is taken on
// every edge with start high and busy low. busy never rises, so a new count can be
// given every cycle
// output: done is high for exactly one cycle with pressure_grams, region and
// channel_out; the receiver has no way to hold a result back, so it must take it
// pipeline: the start beat passes the front multiply, the clamp compare, the restoring
// divider with one quotient bit per stage (14 stages) and four curve stages (segment
// pick, two multiplies, add) before done is raised
// throughput: one count per cycle, results leave in the order the counts came in
// config: fixed_res_reg is written from cfg_data when cfg_valid is high;
// cfg_ready is always high. write it only while no count is in flight
// reset: rst_n clears every valid bit at once, so no done is raised for counts in
// flight, and sets the resistor value back to 10000 ohm
module divider_resistance_to_pressure (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [drp_pkg::ADC_BITS-1:0] adc_count,
    input  logic [drp_pkg::CHAN_W-1:0]   channel,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [drp_pkg::RES_W-1:0]    cfg_data,
    output logic                         done,
    output logic [drp_pkg::GRAM_W-1:0]   pressure_grams,
    output logic [drp_pkg::REGION_W-1:0] region,
    output logic [drp_pkg::CHAN_W-1:0]   channel_out
);
    import drp_pkg::*;

    logic [RES_W-1:0] fixed_res_reg;

    logic                s0_valid_reg;
    logic [NUM_W-1:0]    s0_num_reg;
    logic [NUM_W-1:0]    s0_num_next;
    logic [ADC_BITS-1:0] s0_den_reg;
    logic [ADC_BITS-1:0] s0_den_next;
    logic [DIV_W-1:0]    s0_lim_reg;
    logic [DIV_W-1:0]    s0_lim_next;
    logic                s0_special_reg;
    logic                s0_special_next;
    logic [CHAN_W-1:0]   s0_chan_reg;

    logic                s1_valid_reg;
    logic [DIV_W-1:0]    s1_num_reg;
    logic [ADC_BITS-1:0] s1_den_reg;
    drp_tag_t            s1_tag_reg;
    drp_tag_t            s1_tag_next;

    logic                div_valid;
    logic [QUO_W-1:0]    div_quo;
    drp_tag_t            div_tag;
    drp_region_t         out_region;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_res_reg <= RES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            fixed_res_reg <= cfg_data;
        end
    end

    // zero count is a short, full scale an open sensor: both read as no load
    assign s0_special_next = (adc_count == '0) || (adc_count == FULL_SCALE);
    assign s0_den_next     = FULL_SCALE - adc_count;
    assign s0_num_next     = NUM_W'(adc_count) * NUM_W'(fixed_res_reg);
    // numerator limit for the top breakpoint, so the quotient never needs more bits
    assign s0_lim_next     = DIV_W'(s0_den_next) * DIV_W'(CURVE_OHM[0]);

    assign s1_tag_next.chan    = s0_chan_reg;
    assign s1_tag_next.no_load = s0_special_reg || (s0_num_reg >= NUM_W'(s0_lim_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start && !busy;
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_num_reg     <= s0_num_next;
        s0_den_reg     <= s0_den_next;
        s0_lim_reg     <= s0_lim_next;
        s0_special_reg <= s0_special_next;
        s0_chan_reg    <= channel;

        s1_num_reg     <= s0_num_reg[DIV_W-1:0];
        s1_den_reg     <= s0_den_reg;
        s1_tag_reg     <= s1_tag_next;
    end

    drp_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_num    (s1_num_reg),
        .in_den    (s1_den_reg),
        .in_tag    (s1_tag_reg),
        .out_valid (div_valid),
        .out_quo   (div_quo),
        .out_tag   (div_tag)
    );

    drp_interp u_interp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (div_valid),
        .in_ohm     (div_quo),
        .in_tag     (div_tag),
        .out_valid  (done),
        .out_grams  (pressure_grams),
        .out_region (out_region),
        .out_chan   (channel_out)
    );

    assign region = out_region;

endmodule

// ===== rtl/core/drp_divider.sv =====
module drp_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [drp_pkg::DIV_W-1:0]   in_num,
    input  logic [drp_pkg::ADC_BITS-1:0] in_den,
    input  drp_pkg::drp_tag_t           in_tag,
    output logic                        out_valid,
    output logic [drp_pkg::QUO_W-1:0]   out_quo,
    output drp_pkg::drp_tag_t           out_tag
);
    import drp_pkg::*;

    logic                valid_reg [QUO_W];
    logic [DIV_W-1:0]    rem_reg   [QUO_W];
    logic [ADC_BITS-1:0] den_reg   [QUO_W];
    logic [QUO_W-1:0]    quo_reg   [QUO_W];
    drp_tag_t            tag_reg   [QUO_W];

    // restoring division, one quotient bit per stage, msb first
    for (genvar s = 0; s < QUO_W; s++) begin : g_step
        localparam int BIT = QUO_W - 1 - s;

        logic                prev_valid;
        logic [DIV_W-1:0]    prev_rem;
        logic [ADC_BITS-1:0] prev_den;
        logic [QUO_W-1:0]    prev_quo;
        drp_tag_t            prev_tag;
        logic [DIV_W-1:0]    trial;
        logic                take;
        logic [DIV_W-1:0]    rem_next;
        logic [QUO_W-1:0]    quo_next;

        if (s == 0) begin : g_first
            assign prev_valid = in_valid;
            assign prev_rem   = in_num;
            assign prev_den   = in_den;
            assign prev_quo   = '0;
            assign prev_tag   = in_tag;
        end
        else begin : g_rest
            assign prev_valid = valid_reg[s-1];
            assign prev_rem   = rem_reg[s-1];
            assign prev_den   = den_reg[s-1];
            assign prev_quo   = quo_reg[s-1];
            assign prev_tag   = tag_reg[s-1];
        end

        assign trial    = DIV_W'(prev_den) << BIT;
        assign take     = prev_rem >= trial;
        assign rem_next = take ? prev_rem - trial : prev_rem;
        assign quo_next = prev_quo | (QUO_W'(take) << BIT);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else
            begin
                valid_reg[s] <= prev_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= rem_next;
            den_reg[s] <= prev_den;
            quo_reg[s] <= quo_next;
            tag_reg[s] <= prev_tag;
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];
    assign out_tag   = tag_reg[QUO_W-1];

endmodule

// ===== rtl/core/drp_interp.sv =====
module drp_interp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [drp_pkg::QUO_W-1:0]  in_ohm,
    input  drp_pkg::drp_tag_t          in_tag,
    output logic                       out_valid,
    output logic [drp_pkg::GRAM_W-1:0] out_grams,
    output drp_pkg::drp_region_t       out_region,
    output logic [drp_pkg::CHAN_W-1:0] out_chan
);
    import drp_pkg::*;

    // segment select
    logic              a_valid_reg;
    drp_region_t       a_region_reg;
    drp_region_t       a_region_next;
    logic [SEG_W-1:0]  a_seg_reg;
    logic [SEG_W-1:0]  a_seg_next;
    logic [DELTA_W-1:0] a_delta_reg;
    logic [DELTA_W-1:0] a_delta_next;
    logic [CHAN_W-1:0] a_chan_reg;

    // offset times slope numerator
    logic              b_valid_reg;
    drp_region_t       b_region_reg;
    logic [SEG_W-1:0]  b_seg_reg;
    logic [PROD_W-1:0] b_prod_reg;
    logic [PROD_W-1:0] b_prod_next;
    logic [CHAN_W-1:0] b_chan_reg;

    // reciprocal multiply for the slope denominator
    logic                c_valid_reg;
    drp_region_t         c_region_reg;
    logic [SEG_W-1:0]    c_seg_reg;
    logic [SCALED_W-1:0] c_scaled_reg;
    logic [SCALED_W-1:0] c_scaled_next;
    logic [CHAN_W-1:0]   c_chan_reg;

    logic              o_valid_reg;
    logic [GRAM_W-1:0] o_grams_reg;
    logic [GRAM_W-1:0] o_grams_next;
    drp_region_t       o_region_reg;
    logic [CHAN_W-1:0] o_chan_reg;

    always_comb
    begin
        if (in_tag.no_load)
            a_region_next = REGION_NONE;
        else if (in_ohm <= CURVE_OHM[CURVE_POINTS-1])
            a_region_next = REGION_FULL;
        else
            a_region_next = REGION_INTERP;

        // lowest segment whose lower breakpoint is not above the resistance
        a_seg_next = SEG_W'(CURVE_POINTS - 2);
        for (int i = CURVE_POINTS - 2; i >= 0; i--)
        begin
            if (in_ohm >= CURVE_OHM[i+1])
                a_seg_next = SEG_W'(i);
        end
        a_delta_next = DELTA_W'(CURVE_OHM[a_seg_next] - in_ohm);
    end

    assign b_prod_next   = PROD_W'(a_delta_reg) * PROD_W'(seg_mul(a_seg_reg));
    assign c_scaled_next = SCALED_W'(b_prod_reg) * SCALED_W'(seg_recip(b_seg_reg));

    always_comb
    begin
        case (c_region_reg)
            REGION_NONE:   o_grams_next = '0;
            REGION_FULL:   o_grams_next = CURVE_GRAM[CURVE_POINTS-1];
            REGION_INTERP: o_grams_next = CURVE_GRAM[c_seg_reg]
                                          + c_scaled_reg[RECIP_SHIFT +: GRAM_W];
            default:       o_grams_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            o_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_region_reg <= a_region_next;
        a_seg_reg    <= a_seg_next;
        a_delta_reg  <= a_delta_next;
        a_chan_reg   <= in_tag.chan;

        b_region_reg <= a_region_reg;
        b_seg_reg    <= a_seg_reg;
        b_prod_reg   <= b_prod_next;
        b_chan_reg   <= a_chan_reg;

        c_region_reg <= b_region_reg;
        c_seg_reg    <= b_seg_reg;
        c_scaled_reg <= c_scaled_next;
        c_chan_reg   <= b_chan_reg;

        o_grams_reg  <= o_grams_next;
        o_region_reg <= c_region_reg;
        o_chan_reg   <= c_chan_reg;
    end

    assign out_valid  = o_valid_reg;
    assign out_grams  = o_grams_reg;
    assign out_region = o_region_reg;
    assign out_chan   = o_chan_reg;

endmodule

// ===== rtl/core/drp_checker.sv =====
module drp_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [drp_pkg::CHAN_W-1:0]   channel,
    input logic                         done,
    input logic [drp_pkg::GRAM_W-1:0]   pressure_grams,
    input logic [drp_pkg::REGION_W-1:0] region,
    input logic [drp_pkg::CHAN_W-1:0]   channel_out
);
    import drp_pkg::*;

    // every accepted beat comes back after the fixed pipeline depth
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LATENCY done)
        else $error("result missing after accepted beat");

    a_channel: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LATENCY (channel_out == $past(channel, PIPE_LATENCY)))
        else $error("channel tag not carried with its result");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && region == REGION_FULL) |-> pressure_grams == CURVE_GRAM[CURVE_POINTS-1])
        else $error("full scale clamp with wrong load");

    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        (done && region == REGION_NONE) |-> pressure_grams == '0)
        else $error("no load region with nonzero load");

    a_interp: assert property (@(posedge clk) disable iff (!rst_n)
        (done && region == REGION_INTERP) |-> pressure_grams < CURVE_GRAM[CURVE_POINTS-1])
        else $error("interpolated load reaches full scale");

endmodule

bind divider_resistance_to_pressure drp_checker u_drp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .channel        (channel),
    .done           (done),
    .pressure_grams (pressure_grams),
    .region         (region),
    .channel_out    (channel_out)
);

// ===== tb/sv/divider_resistance_to_pressure_test.sv =====
`timescale 1ns / 100ps

module divider_resistance_to_pressure_test;

    import drp_pkg::ADC_BITS;
    import drp_pkg::RES_W;
    import drp_pkg::GRAM_W;
    import drp_pkg::CHAN_W;
    import drp_pkg::PIPE_LATENCY;
    import drp_pkg::drp_region_t;
    import drp_pkg::REGION_NONE;
    import drp_pkg::REGION_INTERP;
    import drp_pkg::REGION_FULL;

    localparam int unsigned ADC_FULL    = (1 << ADC_BITS) - 1;
    localparam int unsigned RES_DEFAULT = 10000;
    localparam int unsigned RES_TOP     = (1 << RES_W) - 1;
    localparam int          BENDS       = 7;
    localparam int unsigned CAL_OHM [BENDS] = '{8500, 6500, 5000, 3300, 2700, 2300, 2000};
    localparam int unsigned CAL_GRAM[BENDS] = '{0, 500, 1000, 2000, 3000, 4000, 5000};

    typedef struct packed {
        logic [GRAM_W-1:0] grams;
        drp_region_t       region;
        logic [CHAN_W-1:0] chan;
    } load_reading_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [ADC_BITS-1:0] adc_count;
    logic [CHAN_W-1:0]   channel;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [RES_W-1:0]    cfg_data;
    logic                done;
    logic [GRAM_W-1:0]   pressure_grams;
    logic [1:0]          region;
    logic [CHAN_W-1:0]   channel_out;

    load_reading_t    expected_loads[$];
    load_reading_t    want_load;
    logic [RES_W-1:0] resistor_ohm;
    int               mismatches;
    int               burst_left;
    bit               gaps_on;

    divider_resistance_to_pressure u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .adc_count      (adc_count),
        .channel        (channel),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .done           (done),
        .pressure_grams (pressure_grams),
        .region         (region),
        .channel_out    (channel_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // divider resistance, then the piecewise curve with clamps at both ends
    function automatic load_reading_t predict_load(input logic [ADC_BITS-1:0] count,
                                                   input logic [CHAN_W-1:0] chan,
                                                   input logic [RES_W-1:0] res);
        load_reading_t     r;
        longint unsigned   ohm;
        longint unsigned   num;
        int                i;
        r.grams  = '0;
        r.region = REGION_NONE;
        r.chan   = chan;
        if (count != 0 && count < ADC_FULL)
        begin
            ohm = (longint'(count) * longint'(res)) / (ADC_FULL - count);
            if (ohm >= CAL_OHM[0])
            begin
                r.grams  = GRAM_W'(CAL_GRAM[0]);
                r.region = REGION_NONE;
            end
            else if (ohm <= CAL_OHM[BENDS-1])
            begin
                r.grams  = GRAM_W'(CAL_GRAM[BENDS-1]);
                r.region = REGION_FULL;
            end
            else
            begin
                for (i = 0; i < BENDS - 1; i++)
                begin
                    if (ohm <= CAL_OHM[i] && ohm >= CAL_OHM[i+1])
                    begin
                        num = (CAL_OHM[i] - ohm) * (CAL_GRAM[i+1] - CAL_GRAM[i]);
                        r.grams  = GRAM_W'(CAL_GRAM[i] + num / (CAL_OHM[i] - CAL_OHM[i+1]));
                        r.region = REGION_INTERP;
                        break;
                    end
                end
            end
        end
        return r;
    endfunction

    // start is left high so back-to-back beats need no second assignment
    task automatic send_count(input logic [ADC_BITS-1:0] count, input logic [CHAN_W-1:0] chan);
        start     <= 1'b1;
        adc_count <= count;
        channel   <= chan;
        do @(posedge clk); while (busy !== 1'b0);
        expected_loads.push_back(predict_load(count, chan, resistor_ohm));
    endtask

    // pipeline must be empty before the resistor changes
    task automatic write_resistor(input logic [RES_W-1:0] value);
        start <= 1'b0;
        while (expected_loads.size() != 0) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid    <= 1'b0;
        resistor_ohm  = value;
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 25) : $urandom_range(0, 4);
            if (gaps_on && gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (expected_loads.size() == 0)
            begin
                $error("unexpected result beat: grams %0d region %0d channel %0d",
                       pressure_grams, region, channel_out);
                mismatches++;
            end
            else
            begin
                want_load = expected_loads.pop_front();
                if (pressure_grams !== want_load.grams)
                begin
                    $error("pressure_grams: expected %0d actual %0d", want_load.grams,
                           pressure_grams);
                    mismatches++;
                end
                if (region !== want_load.region)
                begin
                    $error("region: expected %0d actual %0d", want_load.region, region);
                    mismatches++;
                end
                if (channel_out !== want_load.chan)
                begin
                    $error("channel_out: expected %0d actual %0d", want_load.chan,
                           channel_out);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_reset_default();
        send_count(ADC_BITS'(0), CHAN_W'(0));
        send_count(ADC_BITS'(ADC_FULL), CHAN_W'(1));
        send_count(ADC_BITS'(1), CHAN_W'(2));
        send_count(ADC_BITS'(ADC_FULL - 1), CHAN_W'(3));
        send_count(ADC_BITS'(1 << (ADC_BITS - 1)), CHAN_W'(3));
        send_count(ADC_BITS'(1900), CHAN_W'(0));
    endtask

    // count 819 gives resistance = resistor / 4 exactly
    task automatic test_breakpoints();
        int i;
        for (i = 0; i < BENDS; i++)
        begin
            write_resistor(RES_W'(4 * CAL_OHM[i]));
            send_count(ADC_BITS'(819), CHAN_W'(i));
        end
        write_resistor(RES_W'(4 * (CAL_OHM[0] - 1)));
        send_count(ADC_BITS'(819), CHAN_W'(1));
        write_resistor(RES_W'(4 * (CAL_OHM[BENDS-1] + 1)));
        send_count(ADC_BITS'(819), CHAN_W'(2));
    endtask

    task automatic test_zero_resistor();
        write_resistor(RES_W'(0));
        send_count(ADC_BITS'(1000), CHAN_W'(2));
        send_count(ADC_BITS'(0), CHAN_W'(1));
        send_count(ADC_BITS'(ADC_FULL), CHAN_W'(0));
    endtask

    task automatic test_max_resistor();
        write_resistor(RES_W'(RES_TOP));
        send_count(ADC_BITS'(ADC_FULL - 1), CHAN_W'(1));
        send_count(ADC_BITS'(1), CHAN_W'(3));
    endtask

    task automatic test_random_loads();
        logic [RES_W-1:0] settings[10];
        int               p;
        int               n;
        int               c;
        longint unsigned  target;
        settings = '{RES_W'(RES_DEFAULT), RES_W'(1000), RES_W'(100000), RES_W'(RES_TOP),
                     RES_W'(0), RES_W'($urandom_range(1000, 100000)),
                     RES_W'($urandom_range(1000, 100000)), RES_W'($urandom),
                     RES_W'($urandom_range(1000, 20000)), RES_W'(RES_DEFAULT)};
        for (p = 0; p < 10; p++)
        begin
            write_resistor(settings[p]);
            gaps_on    = (p % 3) != 2;
            burst_left = 0;
            for (n = 0; n < 130; n++)
            begin
                pace_sender();
                case ($urandom_range(0, 9))
                    0:
                        c = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? 0 : ADC_FULL)
                                                 : ($urandom_range(0, 1) ? 1 : ADC_FULL - 1);
                    1, 2, 3:
                        c = $urandom_range(0, ADC_FULL);
                    default:
                    begin
                        // aim at the curve so most beats are interpolated
                        target = $urandom_range(1900, 8600);
                        c = int'((target * ADC_FULL) / (settings[p] + target));
                        c = c + int'($urandom_range(0, 6)) - 3;
                        if (c < 0) c = 0;
                        if (c > ADC_FULL) c = ADC_FULL;
                    end
                endcase
                send_count(ADC_BITS'(c), CHAN_W'($urandom_range(0, 3)));
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        adc_count    = '0;
        channel      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        mismatches   = 0;
        burst_left   = 0;
        gaps_on      = 1'b1;
        resistor_ohm = RES_W'(RES_DEFAULT);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_default();
        test_breakpoints();
        test_zero_resistor();
        test_max_resistor();
        test_random_loads();

        start <= 1'b0;
        while (expected_loads.size() != 0) @(posedge clk);
        repeat (PIPE_LATENCY + 5) @(posedge clk);
        if (expected_loads.size() != 0)
        begin
            $error("%0d results never arrived", expected_loads.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/drp_pkg.sv
rtl/core/drp_divider.sv
rtl/core/drp_interp.sv
rtl/core/divider_resistance_to_pressure.sv
rtl/core/drp_checker.sv
tb/sv/divider_resistance_to_pressure_test.sv
